// ===== rtl/sha_pkg.sv =====
// SHA-256 hasher shared definitions: round constants, initial hash, sigma functions.
// No dependencies.
package sha_pkg;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned HashWords = 8;
	localparam int unsigned QueueDepth = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       msg_last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} back_state_t;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/sha256_message_hasher_top.sv =====
// SHA-256 message hasher top level: input queue plus compression engine.
// A byte is taken from the queue head while the engine is idle; a full block then runs 64 rounds and an add.
// Message end: each padding block runs pad, 64 rounds and add, then 8 digest words are output.
// Throughput is bounded by the single round unit: no byte is taken while a block is compressed.
// Reset (arst_n low, asynchronous) restores the initial hash and empties the queue.
// Depends on sha_pkg, sha_front, sha_back.
module sha256_message_hasher_top import sha_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        msg_last,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	item_t in_item, head_item;
	logic has_item, take;

	assign in_item = '{data_byte: data_byte, has_byte: has_byte, msg_last: msg_last};

	sha_front #(.Depth(Depth)) u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.has_item, .head_item, .take
	);

	sha_back u_back (
		.clk, .arst_n, .has_item, .head_item, .take,
		.empty, .pop, .digest_word, .word_index, .digest_last
	);
endmodule

// ===== rtl/sha_front.sv =====
// Input side: queue of accepted items between the port and the compression engine.
// Depends on sha_pkg.
module sha_front import sha_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t in_item,
	output logic  has_item,
	output item_t head_item,
	input  logic  take
);
	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	item_t mem_q [Depth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0] cnt_q;
	logic do_push, do_pop;

	// bare items (no byte, no end) change nothing, so they are dropped here
	assign full = (cnt_q == (Aw+1)'(Depth));
	assign do_push = push && !full && (in_item.has_byte || in_item.msg_last);
	assign has_item = (cnt_q != '0);
	assign do_pop = take && has_item;
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
		end
	end
endmodule

// ===== rtl/sha_back.sv =====
// Compression engine: packs bytes, pads, runs 64 rounds per block, emits the digest.
// Depends on sha_pkg.
module sha_back import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        has_item,
	input  item_t       head_item,
	output logic        take,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	back_state_t state_q, state_d;

	logic [31:0] w_q [BlockWords];
	logic [31:0] h_q [HashWords];
	logic [31:0] v_q [HashWords];
	logic [60:0] cnt_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        final_q;   // compression in flight is the message's last block
	logic        pad_done_q; // 0x80 already placed (second pad block pending)
	// pend_last_q: a message end waiting behind a block that filled on its final byte
	logic        pend_last_q;

	logic [31:0] t1, t2, wnew;
	logic [63:0] bits;
	logic        len_here;   // this pad block carries the bit length

	assign bits = {cnt_q, 3'b000};
	assign len_here = pad_done_q || (fill_q <= 6'd55);
	assign wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_q[0];
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign empty = (state_q != ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign digest_last = (oidx_q == 3'd7);
	assign take = (state_q == ST_IDLE) && has_item;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (has_item) begin
					if (head_item.has_byte && fill_q == 6'd63) state_d = ST_ROUND;
					else if (head_item.msg_last) state_d = ST_PAD;
				end
			end
			ST_PAD:   state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (final_q) state_d = ST_OUT;
				else if (pad_done_q || pend_last_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_OUT: if (pop && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) h_q[i] <= InitHash[i];
			cnt_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			final_q <= 1'b0;
			pad_done_q <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (has_item && head_item.has_byte) begin
						fill_q <= fill_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
						if (fill_q == 6'd63) begin
							pend_last_q <= head_item.msg_last;
							final_q <= 1'b0;
							pad_done_q <= 1'b0;
							rnd_q <= '0;
						end
					end
				end
				ST_PAD: begin
					rnd_q <= '0;
					if (!pad_done_q && fill_q > 6'd55) begin
						pad_done_q <= 1'b1;
						final_q <= 1'b0;
					end else begin
						final_q <= 1'b1;
					end
					pend_last_q <= 1'b0;
				end
				ST_ROUND: rnd_q <= rnd_q + 1'b1;
				ST_ADD: begin
					for (int i = 0; i < HashWords; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q <= '0;
				end
				ST_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < HashWords; i++) h_q[i] <= InitHash[i];
							cnt_q <= '0;
							fill_q <= '0;
							final_q <= 1'b0;
							pad_done_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// round variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && has_item && head_item.has_byte) begin
			if (fill_q == 6'd63)
				for (int i = 0; i < HashWords; i++) v_q[i] <= h_q[i];
			if (fill_q[1:0] == 2'd0)
				w_q[fill_q[5:2]] <= {head_item.data_byte, 24'h0};
			else
				for (int b = 1; b < 4; b++)
					if (fill_q[1:0] == 2'(b))
						w_q[fill_q[5:2]][31-8*b -: 8] <= head_item.data_byte;
		end else if (state_q == ST_PAD) begin
			for (int i = 0; i < HashWords; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < BlockWords; i++) begin
				if (len_here && i == BlockWords - 2) begin
					w_q[i] <= bits[63:32];
				end else if (len_here && i == BlockWords - 1) begin
					w_q[i] <= bits[31:0];
				end else if (pad_done_q) begin
					w_q[i] <= '0;
				end else if (4'(i) > fill_q[5:2]) begin
					w_q[i] <= '0;
				end else if (4'(i) == fill_q[5:2]) begin
					for (int b = 0; b < 4; b++) begin
						if (fill_q[1:0] == 2'(b)) w_q[i][31-8*b -: 8] <= PadByte;
						else if (fill_q[1:0] < 2'(b)) w_q[i][31-8*b -: 8] <= 8'h00;
					end
				end
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule

// ===== tb/sv/tb_sha256_message_hasher_top.sv =====
// Self-checking testbench for sha256_message_hasher_top: byte items in, digest words out.
// Predicts digests with a local SHA-256 model; depends on sha_pkg and the RTL top level.
module tb_sha256_message_hasher_top;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        has_byte = 1'b0;
	logic        msg_last = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	item_t   pending_items[$];
	digest_t expected_digests[$];
	int      errors = 0;
	bit      stim_done = 1'b0;

	// predictor state
	logic [31:0] hash_st[8];
	logic [31:0] blk_w[16];
	logic [60:0] msg_bytes;
	logic [5:0]  fill;

	sha256_message_hasher_top u_dut (.*);

	always #4 clk = ~clk;

	function automatic logic [31:0] rr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic add_item(item_t it);
		pending_items = {pending_items, it};
	endtask

	task automatic add_expected(digest_t d);
		expected_digests = {expected_digests, d};
	endtask

	task automatic compress();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk_w[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = hash_st[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
			t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_st[i] += v[i];
	endtask

	task automatic place_byte(int pos, logic [7:0] b);
		int sh;
		sh = 24 - 8 * (pos % 4);
		if (pos % 4 == 0)
			blk_w[pos/4] = {b, 24'h0};
		else
			blk_w[pos/4][sh +: 8] = b;
	endtask

	task automatic hasher_reset();
		for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
		msg_bytes = '0;
		fill = '0;
	endtask

	task automatic predict_digest(item_t it);
		int pos;
		logic [63:0] bits;
		if (it.has_byte) begin
			place_byte(fill, it.data_byte);
			fill++;
			msg_bytes++;
			if (fill == 0) compress();
		end
		if (!it.msg_last) return;
		place_byte(fill, PadByte);
		pos = fill + 1;
		if (pos > 56) begin
			for (; pos < 64; pos++) place_byte(pos, 8'h00);
			compress();
			pos = 0;
		end
		for (; pos < 56; pos++) place_byte(pos, 8'h00);
		bits = {msg_bytes, 3'b000};
		blk_w[14] = bits[63:32];
		blk_w[15] = bits[31:0];
		compress();
		for (int i = 0; i < 8; i++)
			add_expected('{hash_st[i], 3'(i), i == 7});
		hasher_reset();
	endtask

	task automatic add_msg(int len, bit bare_end);
		for (int i = 0; i < len; i++)
			add_item('{8'($urandom), 1'b1, (i == len - 1) && !bare_end});
		if (bare_end || len == 0)
			add_item('{8'($urandom), 1'b0, 1'b1});
	endtask

	// accepted items are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			predict_digest('{data_byte, has_byte, msg_last});
			void'(pending_items.pop_front());
		end
	end

	// driver: bursts of pushes with random gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pending_items.size() > 0) begin
				push <= 1'b1;
				{data_byte, has_byte, msg_last} <= pending_items[0];
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver stalls in its own pattern
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase[8])
			pop <= 1'b1;
		else
			pop <= ($urandom_range(0, 99) < 30 + (stall_phase % 7) * 10);
	end

	// monitor
	always @(posedge clk) begin
		digest_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{digest_word, word_index, digest_last};
			if (expected_digests.size() == 0) begin
				$error("unexpected digest item %h", got.word);
				errors++;
			end else begin
				want = expected_digests.pop_front();
				if (got.word !== want.word) begin
					$error("digest_word exp %h got %h", want.word, got.word);
					errors++;
				end
				if (got.idx !== want.idx) begin
					$error("word_index exp %0d got %0d", want.idx, got.idx);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("digest_last exp %0d got %0d", want.last, got.last);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		hasher_reset();
		for (int i = 0; i < 16; i++) blk_w[i] = '0;
		// directed: empty message, padding edges, bare items, extreme bytes
		add_msg(0, 1'b1);
		add_item('{8'hff, 1'b0, 1'b0});
		add_item('{8'hff, 1'b1, 1'b1});
		add_item('{8'h00, 1'b1, 1'b1});
		add_msg(55, 1'b0);
		add_msg(56, 1'b0);
		add_msg(63, 1'b1);
		add_msg(64, 1'b0);
		add_msg(3, 1'b1);
		n = 0;
		while (n < 230) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 30);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					add_item('{8'($urandom), 1'b0, 1'b0});
				add_item('{8'($urandom), 1'b1, 1'b0});
			end
			if (len > 0 && $urandom_range(0, 1))
				pending_items[$].msg_last = 1'b1;
			else
				add_item('{8'($urandom), 1'b0, 1'b1});
			n += len + 1;
		end
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (pending_items.size() == 0);
		@(posedge clk);
		wait (expected_digests.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_digests.size() == 0)
			$display("tb_sha256_message_hasher_top OK");
		else
			$display("tb_sha256_message_hasher_top NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_sha256_message_hasher_top NOT OK");
		$finish;
	end

endmodule
